// ===== rtl/bprp_pkg.sv =====
package bprp_pkg;

    // Default depth of the command queue between front and back (power of two).
    localparam int QUEUE_DEPTH_DEF = 4;

    // Flag bits of the record header byte.
    localparam logic [7:0] FLAG_TIMESTAMP = 8'h02;
    localparam logic [7:0] FLAG_PULSE     = 8'h04;
    localparam logic [7:0] FLAG_USER      = 8'h08;

    // Byte positions within a record.
    localparam logic [4:0] POS_FLAGS      = 5'd0;
    localparam logic [4:0] POS_BASE_LAST  = 5'd5;
    localparam logic [4:0] POS_PRESS_END  = 5'd6;
    localparam logic [4:0] POS_TS_FIRST   = 5'd7;
    localparam logic [4:0] POS_TS_YEAR_HI = 5'd8;
    localparam logic [4:0] POS_TS_END     = 5'd14;
    localparam logic [4:0] POS_MAX        = 5'd31;
    localparam logic [4:0] TS_LEN         = 5'd7;
    localparam logic [4:0] PULSE_LEN      = 5'd2;
    localparam logic [4:0] TS_ID_OFFSET   = 5'd5;

    // Decimal float special mantissas.
    localparam logic [11:0] MANT_NAN       = 12'h7FF;
    localparam logic [11:0] MANT_NRES      = 12'h800;
    localparam logic [11:0] MANT_RESERVED  = 12'h7FE;

    typedef enum logic [3:0] {
        FID_SYS    = 4'd0,
        FID_DIA    = 4'd1,
        FID_MEAN   = 4'd2,
        FID_YEAR   = 4'd3,
        FID_MONTH  = 4'd4,
        FID_DAY    = 4'd5,
        FID_HOUR   = 4'd6,
        FID_MIN    = 4'd7,
        FID_SEC    = 4'd8,
        FID_PULSE  = 4'd9,
        FID_USER   = 4'd10,
        FID_STATUS = 4'd11
    } field_id_t;

    typedef enum logic [1:0] {
        VC_NORMAL = 2'd0,
        VC_NAN    = 2'd1,
        VC_NRES   = 2'd2
    } value_class_t;

    // One queue entry: everything a single input byte causes.
    typedef struct packed {
        logic        press;      // emit sys, dia, mean from raw_a/b/c
        logic        fld_vld;    // emit one optional field from raw_a
        logic [3:0]  fld_id;
        logic        fld_float;
        logic [15:0] raw_a;
        logic [15:0] raw_b;
        logic [15:0] raw_c;
        logic        end_vld;    // emit the status result
        logic        short_rec;
        logic [7:0]  flags;
    } cmd_t;

    function automatic value_class_t float_class(logic [15:0] raw);
        value_class_t cls;
        cls = VC_NORMAL;
        if (raw[11:0] == MANT_NAN)
        begin
            cls = VC_NAN;
        end
        else if (raw[11:0] == MANT_NRES)
        begin
            cls = VC_NRES;
        end
        else if (raw[11:0] == MANT_RESERVED && raw[15:12] == 4'd0)
        begin
            cls = VC_NAN;
        end
        return cls;
    endfunction

endpackage

// ===== rtl/blood_pressure_record_parser_unit.sv =====
// Blood pressure measurement record parser.
//
// Input channel (in_valid / in_stall): one record byte per beat in data_byte,
// with end_of_record high on the final byte of a record. Byte 0 is the flags
// byte; bytes 1..6 carry systolic, diastolic and mean pressure.
// Output channel (out_valid / out_stall): one decoded field per beat. The
// three pressures come out after byte 6, optional timestamp parts, pulse and
// user id follow as each completes, and the final byte adds a status beat
// with last high (record_status high if the record was under 7 bytes).
// Throughput: one byte per cycle is taken while the 4-entry command queue
// has room; results drain one per cycle while the receiver does not stall,
// and a byte that closes the pressures and the record yields four results.
// Each byte's command is written into the queue when the byte is taken; the
// back end then loads its results from the queue head into the output
// register.
// Reset clears the byte position, the flags, the queue and the output valid.
// When the receiver stalls, the output register holds its beat, the queue
// fills, and in_stall rises once the queue is full.
module blood_pressure_record_parser_unit
#(
    parameter int QUEUE_DEPTH = bprp_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               end_of_record,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [3:0]         field_id,
    output logic [15:0]        raw_value,
    output logic signed [11:0] mantissa,
    output logic signed [3:0]  exponent,
    output logic [1:0]         value_class,
    output logic               record_status,
    output logic               last
);

    logic           accept;
    logic           cmd_push;
    bprp_pkg::cmd_t cmd;
    bprp_pkg::cmd_t head;
    logic           not_empty;
    logic           full;
    logic           pop;

    // Take a beat whenever the queue has room for what it may cause.
    assign in_stall = full;
    assign accept   = in_valid && !full;

    // Front: track position and flags, classify the byte into a command.
    bprp_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .data_byte     (data_byte),
        .end_of_record (end_of_record),
        .cmd_push      (cmd_push),
        .cmd           (cmd)
    );

    // Queue: decouple byte intake from result delivery.
    bprp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .full      (full)
    );

    // Back: expand each command into result beats and decode decimal floats.
    bprp_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .not_empty     (not_empty),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .field_id      (field_id),
        .raw_value     (raw_value),
        .mantissa      (mantissa),
        .exponent      (exponent),
        .value_class   (value_class),
        .record_status (record_status),
        .last          (last)
    );

endmodule

// ===== rtl/bprp_front.sv =====
module bprp_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        data_byte,
    input  logic              end_of_record,
    output logic              cmd_push,
    output bprp_pkg::cmd_t    cmd
);

    logic [7:0] flag_bits_reg;
    logic [7:0] flag_bits_next;
    logic [4:0] byte_position_reg;
    logic [4:0] byte_position_next;
    logic [7:0] base_bytes_reg [5];
    logic [7:0] pending_low_byte_reg;
    logic [7:0] pending_low_byte_next;

    logic       has_ts;
    logic       has_pulse;
    logic       has_user;
    logic [4:0] pulse_at;
    logic [4:0] user_at;
    logic       base_we;
    logic [2:0] base_idx;

    assign has_ts    = (flag_bits_reg & bprp_pkg::FLAG_TIMESTAMP) != 8'd0;
    assign has_pulse = (flag_bits_reg & bprp_pkg::FLAG_PULSE) != 8'd0;
    assign has_user  = (flag_bits_reg & bprp_pkg::FLAG_USER) != 8'd0;
    assign pulse_at  = bprp_pkg::POS_TS_FIRST + (has_ts ? bprp_pkg::TS_LEN : 5'd0);
    assign user_at   = pulse_at + (has_pulse ? bprp_pkg::PULSE_LEN : 5'd0);
    assign base_idx  = byte_position_reg[2:0] - 3'd1;

    always_comb
    begin
        flag_bits_next        = flag_bits_reg;
        pending_low_byte_next = pending_low_byte_reg;
        base_we               = 1'b0;
        cmd                   = '0;

        if (byte_position_reg == bprp_pkg::POS_FLAGS)
        begin
            flag_bits_next = data_byte;
        end
        else if (byte_position_reg <= bprp_pkg::POS_BASE_LAST)
        begin
            base_we = 1'b1;
        end
        else if (byte_position_reg == bprp_pkg::POS_PRESS_END)
        begin
            cmd.press = 1'b1;
            cmd.raw_a = {base_bytes_reg[1], base_bytes_reg[0]};
            cmd.raw_b = {base_bytes_reg[3], base_bytes_reg[2]};
            cmd.raw_c = {data_byte, base_bytes_reg[4]};
        end
        else if (has_ts && byte_position_reg < bprp_pkg::POS_TS_END)
        begin
            if (byte_position_reg == bprp_pkg::POS_TS_FIRST)
            begin
                pending_low_byte_next = data_byte;
            end
            else if (byte_position_reg == bprp_pkg::POS_TS_YEAR_HI)
            begin
                cmd.fld_vld = 1'b1;
                cmd.fld_id  = bprp_pkg::FID_YEAR;
                cmd.raw_a   = {data_byte, pending_low_byte_reg};
            end
            else
            begin
                cmd.fld_vld = 1'b1;
                cmd.fld_id  = 4'(byte_position_reg - bprp_pkg::TS_ID_OFFSET);
                cmd.raw_a   = {8'd0, data_byte};
            end
        end
        else if (has_pulse && byte_position_reg == pulse_at)
        begin
            pending_low_byte_next = data_byte;
        end
        else if (has_pulse && byte_position_reg == pulse_at + 5'd1)
        begin
            cmd.fld_vld   = 1'b1;
            cmd.fld_id    = bprp_pkg::FID_PULSE;
            cmd.fld_float = 1'b1;
            cmd.raw_a     = {data_byte, pending_low_byte_reg};
        end
        else if (has_user && byte_position_reg == user_at)
        begin
            cmd.fld_vld = 1'b1;
            cmd.fld_id  = bprp_pkg::FID_USER;
            cmd.raw_a   = {8'd0, data_byte};
        end

        cmd.end_vld   = end_of_record;
        cmd.short_rec = byte_position_reg < bprp_pkg::POS_PRESS_END;
        cmd.flags     = flag_bits_next;

        if (end_of_record)
        begin
            byte_position_next = bprp_pkg::POS_FLAGS;
        end
        else if (byte_position_reg < bprp_pkg::POS_MAX)
        begin
            byte_position_next = byte_position_reg + 5'd1;
        end
        else
        begin
            byte_position_next = byte_position_reg;
        end
    end

    assign cmd_push = accept && (cmd.press || cmd.fld_vld || cmd.end_vld);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_bits_reg     <= '0;
            byte_position_reg <= '0;
        end
        else if (accept)
        begin
            flag_bits_reg     <= flag_bits_next;
            byte_position_reg <= byte_position_next;
        end
    end

    // Record bytes: written before every read within a record.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pending_low_byte_reg <= pending_low_byte_next;
            if (base_we)
            begin
                base_bytes_reg[base_idx] <= data_byte;
            end
        end
    end

endmodule

// ===== rtl/bprp_queue.sv =====
module bprp_queue
#(
    parameter int DEPTH = bprp_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  bprp_pkg::cmd_t    push_data,
    input  logic              pop,
    output bprp_pkg::cmd_t    head,
    output logic              not_empty,
    output logic              full
);

    localparam int AW = $clog2(DEPTH);

    bprp_pkg::cmd_t entries_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg;
    logic [AW-1:0]  rd_ptr_reg;
    logic [AW:0]    count_reg;

    assign head      = entries_reg[rd_ptr_reg];
    assign not_empty = count_reg != '0;
    assign full      = count_reg == (AW+1)'(DEPTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (AW+1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (AW+1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/bprp_back.sv =====
module bprp_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  bprp_pkg::cmd_t     head,
    input  logic               not_empty,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [3:0]         field_id,
    output logic [15:0]        raw_value,
    output logic signed [11:0] mantissa,
    output logic signed [3:0]  exponent,
    output logic [1:0]         value_class,
    output logic               record_status,
    output logic               last
);

    logic [1:0]  step_reg;
    logic        out_valid_reg;
    logic [3:0]  field_id_reg;
    logic [15:0] raw_value_reg;
    logic [11:0] mantissa_reg;
    logic [3:0]  exponent_reg;
    logic [1:0]  value_class_reg;
    logic        record_status_reg;
    logic        last_reg;

    logic        issue;
    logic [2:0]  sub_count;
    logic        last_sub;
    logic [1:0]  idx;
    logic [3:0]  sel_id;
    logic [15:0] sel_raw;
    logic        sel_float;
    logic        sel_status;
    logic        sel_last;

    assign issue     = not_empty && (!out_valid_reg || !out_stall);
    assign sub_count = (head.press ? 3'd3 : 3'd0) + {2'd0, head.fld_vld}
                       + {2'd0, head.end_vld};
    assign last_sub  = {1'b0, step_reg} == sub_count - 3'd1;
    assign pop       = issue && last_sub;
    assign idx       = step_reg - (head.press ? 2'd3 : 2'd0);

    // Walk the entry: pressures first, then the optional field, then status.
    always_comb
    begin
        sel_id     = bprp_pkg::FID_STATUS;
        sel_raw    = {8'd0, head.flags};
        sel_float  = 1'b0;
        sel_status = head.short_rec;
        sel_last   = 1'b1;
        if (head.press && step_reg != 2'd3)
        begin
            sel_id     = bprp_pkg::FID_SYS + {2'd0, step_reg};
            sel_float  = 1'b1;
            sel_status = 1'b0;
            sel_last   = 1'b0;
            unique case (step_reg)
                2'd0:    sel_raw = head.raw_a;
                2'd1:    sel_raw = head.raw_b;
                default: sel_raw = head.raw_c;
            endcase
        end
        else if (head.fld_vld && idx == 2'd0)
        begin
            sel_id     = head.fld_id;
            sel_raw    = head.raw_a;
            sel_float  = head.fld_float;
            sel_status = 1'b0;
            sel_last   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                step_reg <= last_sub ? 2'd0 : step_reg + 2'd1;
            end
            if (issue)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            field_id_reg      <= sel_id;
            raw_value_reg     <= sel_raw;
            mantissa_reg      <= sel_float ? sel_raw[11:0] : 12'd0;
            exponent_reg      <= sel_float ? sel_raw[15:12] : 4'd0;
            value_class_reg   <= sel_float ? bprp_pkg::float_class(sel_raw)
                                           : bprp_pkg::VC_NORMAL;
            record_status_reg <= sel_status;
            last_reg          <= sel_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign field_id      = field_id_reg;
    assign raw_value     = raw_value_reg;
    assign mantissa      = signed'(mantissa_reg);
    assign exponent      = signed'(exponent_reg);
    assign value_class   = value_class_reg;
    assign record_status = record_status_reg;
    assign last          = last_reg;

endmodule
